>>> design/smat_pkg.sv
package smat_pkg;

  // matrix limits
  localparam int MAX_DIM = 8;
  localparam int DIM_W   = 4;
  localparam int IDX_W   = 3;
  localparam int ADDR_W  = 6;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ELEM_W  = 16;
  localparam int VALUE_W = 35;
  localparam int COUNT_W = 8;
  localparam int LEN_W   = 7;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 4'd3;

  // operation codes
  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_MULTIPLY  = 2'd1;
  localparam logic [1:0] OP_TRANSPOSE = 2'd2;

  // dimension register to effective size, zero acts as one, values above MAX_DIM act as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) d = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) d = DIM_W'(MAX_DIM);
    else d = v;
    return d;
  endfunction

endpackage

>>> design/smat_if.sv
// element word channel
interface smat_elem_if import smat_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element;
  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

// result word channel
interface smat_res_if import smat_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [IDX_W-1:0]          row;
  logic [IDX_W-1:0]          column;
  logic                      final_res;
  modport source (output valid, output value, output row, output column,
                  output final_res, input ready);
  modport sink   (input valid, input value, input row, input column,
                  input final_res, output ready);
endinterface

// register write channel
interface smat_cfg_if import smat_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/smat_ram.sv
module smat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/small_matrix_add_multiply_transpose_core.sv
// Small matrix engine. Elements of A, then of B when the mode needs one, arrive one word
// per cycle in row-major order and are written into two 64-entry RAMs. The word that
// completes the load starts result generation: results leave in row-major order with
// their row and column, the last one flagged by final_res. Each result comes from the
// single read port of each RAM feeding a read, product, accumulate pipeline that walks
// one term per cycle: one term for add or transpose, cols_a terms for multiply. No
// element is accepted while results are being generated; the result register lets the
// next result be computed while the current one waits. A register write restarts
// loading; writes to an index beyond the list are ignored.
module small_matrix_add_multiply_transpose_core import smat_pkg::*; (
  input logic      clk,
  input logic      rst,
  smat_elem_if.sink  elem,
  smat_res_if.source res,
  smat_cfg_if.sink   cfg
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state;
  logic [1:0]       mode;
  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] cols_a;
  logic [DIM_W-1:0] cols_b;
  logic [COUNT_W-1:0] load_count;
  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] j_idx;
  logic [IDX_W-1:0] k_idx;
  logic             p1;
  logic             p2;
  logic signed [VALUE_W-1:0] term;
  logic signed [VALUE_W-1:0] acc;
  logic             out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_column;
  logic             out_final;

  logic [DIM_W-1:0] r_dim;
  logic [DIM_W-1:0] c_dim;
  logic [DIM_W-1:0] k_dim;
  logic [1:0]       op;
  logic [LEN_W-1:0] a_len;
  logic [LEN_W-1:0] b_len;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] b_off;
  logic             accept;
  logic             is_a;
  logic             last_load;
  logic             cfg_hit;
  logic [IDX_W-1:0] i_last;
  logic [IDX_W-1:0] j_last;
  logic [IDX_W-1:0] k_last;
  logic [IDX_W-1:0] a_row;
  logic [IDX_W-1:0] a_col;
  logic [LEN_W-1:0] a_addr_full;
  logic [LEN_W-1:0] b_addr_full;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic [ELEM_W-1:0] a_q;
  logic [ELEM_W-1:0] b_q;
  logic signed [ELEM_W:0]     sum;
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [VALUE_W-1:0]  term_next;
  logic             issue;
  logic             emit;
  logic             final_elem;

  // effective sizes
  assign r_dim = clamp_dim(rows_a);
  assign c_dim = clamp_dim(cols_a);
  assign k_dim = clamp_dim(cols_b);
  assign op    = (mode == OP_MULTIPLY || mode == OP_TRANSPOSE) ? mode : OP_ADD;
  assign a_len = LEN_W'({3'b000, r_dim} * {3'b000, c_dim});
  assign b_len = LEN_W'({3'b000, c_dim} * {3'b000, k_dim});

  // load length per operation
  always_comb begin
    case (op)
      OP_MULTIPLY:  total = {1'b0, a_len} + {1'b0, b_len};
      OP_TRANSPOSE: total = {1'b0, a_len};
      default:      total = {1'b0, a_len} + {1'b0, a_len};
    endcase
  end

  // load side
  assign elem.ready = (state == ST_LOAD);
  assign accept     = elem.valid && elem.ready;
  assign is_a       = load_count < {1'b0, a_len};
  assign b_off      = load_count - {1'b0, a_len};
  assign last_load  = (load_count + COUNT_W'(1)) == total;

  // configuration writes
  assign cfg.ready = 1'b1;
  assign cfg_hit   = cfg.valid && (cfg.index == REG_MODE || cfg.index == REG_ROWS_A ||
                                   cfg.index == REG_COLS_A || cfg.index == REG_COLS_B);

  // loop bounds per operation
  always_comb begin
    case (op)
      OP_MULTIPLY: begin
        i_last = IDX_W'(r_dim - DIM_W'(1));
        j_last = IDX_W'(k_dim - DIM_W'(1));
        k_last = IDX_W'(c_dim - DIM_W'(1));
      end
      OP_TRANSPOSE: begin
        i_last = IDX_W'(c_dim - DIM_W'(1));
        j_last = IDX_W'(r_dim - DIM_W'(1));
        k_last = '0;
      end
      default: begin
        i_last = IDX_W'(r_dim - DIM_W'(1));
        j_last = IDX_W'(c_dim - DIM_W'(1));
        k_last = '0;
      end
    endcase
  end

  // read addresses
  assign a_row = (op == OP_TRANSPOSE) ? j_idx : i_idx;
  assign a_col = (op == OP_MULTIPLY) ? k_idx : ((op == OP_TRANSPOSE) ? i_idx : j_idx);
  assign a_addr_full = LEN_W'({4'b0000, a_row} * {3'b000, c_dim}) + {4'b0000, a_col};
  assign b_addr_full = (op == OP_MULTIPLY)
                     ? LEN_W'({4'b0000, k_idx} * {3'b000, k_dim}) + {4'b0000, j_idx}
                     : LEN_W'({4'b0000, i_idx} * {3'b000, c_dim}) + {4'b0000, j_idx};
  assign a_raddr = a_addr_full[ADDR_W-1:0];
  assign b_raddr = b_addr_full[ADDR_W-1:0];

  smat_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (accept && is_a),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (elem.element),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  smat_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (accept && !is_a),
    .waddr (b_off[ADDR_W-1:0]),
    .wdata (elem.element),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  // term from the read words
  assign sum  = $signed({a_q[ELEM_W-1], a_q}) + $signed({b_q[ELEM_W-1], b_q});
  assign prod = $signed(a_q) * $signed(b_q);
  always_comb begin
    case (op)
      OP_MULTIPLY:  term_next = {{(VALUE_W-2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
      OP_TRANSPOSE: term_next = {{(VALUE_W-ELEM_W){a_q[ELEM_W-1]}}, a_q};
      default:      term_next = {{(VALUE_W-ELEM_W-1){sum[ELEM_W]}}, sum};
    endcase
  end

  // sequencing
  assign issue      = (state == ST_RUN);
  assign emit       = (state == ST_DRAIN) && !p1 && !p2 && (!out_valid || res.ready);
  assign final_elem = (i_idx == i_last) && (j_idx == j_last);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      mode       <= OP_ADD;
      rows_a     <= DIM_W'(MAX_DIM);
      cols_a     <= DIM_W'(MAX_DIM);
      cols_b     <= DIM_W'(MAX_DIM);
      load_count <= '0;
      i_idx      <= '0;
      j_idx      <= '0;
      k_idx      <= '0;
      p1         <= 1'b0;
      p2         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      p1 <= issue;
      p2 <= p1;

      // register writes restart loading
      if (cfg_hit) begin
        load_count <= '0;
        case (cfg.index)
          REG_MODE:   mode   <= cfg.data[1:0];
          REG_ROWS_A: rows_a <= cfg.data;
          REG_COLS_A: cols_a <= cfg.data;
          REG_COLS_B: cols_b <= cfg.data;
          default:    mode   <= mode;
        endcase
      end

      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (last_load) begin
              load_count <= '0;
              i_idx      <= '0;
              j_idx      <= '0;
              k_idx      <= '0;
              state      <= ST_RUN;
            end else begin
              load_count <= load_count + COUNT_W'(1);
            end
          end
        end
        ST_RUN: begin
          if (k_idx == k_last) begin
            k_idx <= '0;
            state <= ST_DRAIN;
          end else begin
            k_idx <= k_idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            if (final_elem) begin
              i_idx <= '0;
              j_idx <= '0;
              state <= ST_LOAD;
            end else begin
              if (j_idx == j_last) begin
                j_idx <= '0;
                i_idx <= i_idx + IDX_W'(1);
              end else begin
                j_idx <= j_idx + IDX_W'(1);
              end
              state <= ST_RUN;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase

      // result register
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    term <= term_next;
    if ((accept && last_load) || (emit && !final_elem)) begin
      acc <= '0;
    end else if (p2) begin
      acc <= acc + term;
    end
    if (emit) begin
      out_value  <= acc;
      out_row    <= i_idx;
      out_column <= j_idx;
      out_final  <= final_elem;
    end
  end

  assign res.valid     = out_valid;
  assign res.value     = out_value;
  assign res.row       = out_row;
  assign res.column    = out_column;
  assign res.final_res = out_final;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench import smat_pkg::*; ();

  // mode value with no operation of its own, and a register index past the list
  localparam logic [CFG_DATA_W-1:0] MODE_SPARE = 4'd3;
  localparam logic [CFG_IDX_W-1:0]  JUNK_INDEX = 4'd9;

  localparam int HOLD_OFF    = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_WORDS = 460;

  typedef enum logic {ST_ELEM, ST_REG} stim_kind_t;

  typedef struct {
    stim_kind_t            kind;
    logic [ELEM_W-1:0]     element;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } stim_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          column;
    logic                      final_res;
  } res_word_t;

  logic clk;
  logic rst;

  smat_elem_if elem_ch ();
  smat_res_if  res_ch ();
  smat_cfg_if  reg_ch ();

  small_matrix_add_multiply_transpose_core u_top (
    .clk (clk),
    .rst (rst),
    .elem(elem_ch),
    .res (res_ch),
    .cfg (reg_ch)
  );

  // matrix engine shadow: registers, stores and load position
  logic [1:0]              m_mode;
  logic [DIM_W-1:0]        m_rows;
  logic [DIM_W-1:0]        m_cols_a;
  logic [DIM_W-1:0]        m_cols_b;
  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  int                      m_loaded;
  res_word_t               due_results[$];

  // stimulus side
  stim_t            stim_q[$];
  stim_t            cur;
  logic             holding;
  int               gap_left;
  int               hold_left;
  int               stall_left;
  logic             src_calm;
  logic             snk_calm;
  int               src_calm_left;
  int               snk_calm_left;
  logic             up_valid;
  logic             up_reg;

  // generator copy of the registers, used only to size the loads
  logic [1:0]       g_mode;
  logic [DIM_W-1:0] g_rows;
  logic [DIM_W-1:0] g_cols_a;
  logic [DIM_W-1:0] g_cols_b;

  // handshake flags sampled at the rising edge
  logic elem_fire;
  logic reg_fire;
  logic word_out;
  int   quiet;
  int   bad_count;

  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [1:0] eff_op(input logic [1:0] md);
    if (md == OP_MULTIPLY || md == OP_TRANSPOSE) return md;
    return OP_ADD;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:   m_mode = data[1:0];
      REG_ROWS_A: m_rows = data;
      REG_COLS_A: m_cols_a = data;
      REG_COLS_B: m_cols_b = data;
      default: ;
    endcase
    // any write inside the list restarts loading
    if (idx <= REG_COLS_B) m_loaded = 0;
  endfunction

  function automatic void push_result(input longint v, input int i, input int j,
                                      input logic last);
    res_word_t o;
    o.value     = v[VALUE_W-1:0];
    o.row       = IDX_W'(i);
    o.column    = IDX_W'(j);
    o.final_res = last;
    due_results.push_back(o);
  endfunction

  // store one element; the word that completes the load yields the whole result matrix
  function automatic void absorb_element(input logic signed [ELEM_W-1:0] e);
    int         r, c, kb, a_len, total, i, j, t;
    logic [1:0] op;
    longint     acc;
    r     = eff_dim(m_rows);
    c     = eff_dim(m_cols_a);
    kb    = eff_dim(m_cols_b);
    op    = eff_op(m_mode);
    a_len = r * c;
    case (op)
      OP_ADD:      total = 2 * a_len;
      OP_MULTIPLY: total = a_len + c * kb;
      default:     total = a_len;
    endcase
    if (m_loaded < a_len) a_mem[m_loaded] = e;
    else b_mem[m_loaded - a_len] = e;
    m_loaded++;
    if (m_loaded < total) return;
    m_loaded = 0;
    case (op)
      OP_ADD: begin
        for (i = 0; i < r; i++)
          for (j = 0; j < c; j++)
            push_result(longint'(a_mem[i*c+j]) + longint'(b_mem[i*c+j]), i, j,
                        i == r - 1 && j == c - 1);
      end
      OP_MULTIPLY: begin
        for (i = 0; i < r; i++)
          for (j = 0; j < kb; j++) begin
            acc = 0;
            for (t = 0; t < c; t++)
              acc += longint'(a_mem[i*c+t]) * longint'(b_mem[t*kb+j]);
            push_result(acc, i, j, i == r - 1 && j == kb - 1);
          end
      end
      default: begin
        for (i = 0; i < c; i++)
          for (j = 0; j < r; j++)
            push_result(longint'(a_mem[j*c+i]), i, j, i == c - 1 && j == r - 1);
      end
    endcase
  endfunction

  task automatic flag_error(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("error at %0t: %s", $time, msg);
  endtask

  // compare one result word with the oldest expected one
  task automatic check_result();
    res_word_t want;
    if (due_results.size() == 0) begin
      flag_error($sformatf("unexpected result value %0d row %0d col %0d last %0b",
                           res_ch.value, res_ch.row, res_ch.column, res_ch.final_res));
    end else begin
      want = due_results.pop_front();
      if (res_ch.value !== want.value || res_ch.row !== want.row ||
          res_ch.column !== want.column || res_ch.final_res !== want.final_res)
        flag_error($sformatf({"expected value %0d row %0d col %0d last %0b, ",
                              "got value %0d row %0d col %0d last %0b"},
                             want.value, want.row, want.column, want.final_res,
                             res_ch.value, res_ch.row, res_ch.column, res_ch.final_res));
    end
  endtask

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ELEM_W-1:0] corner_element();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'h0001;
      default: return 16'h8001;
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] rand_element();
    if ($urandom_range(0, 99) < 15) return corner_element();
    return ELEM_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return DIM_W'($urandom_range(MAX_DIM + 1, 15));
    if (r < 28) return DIM_W'(MAX_DIM);
    return DIM_W'($urandom_range(1, 4));
  endfunction

  function automatic int load_len();
    int a_len;
    a_len = eff_dim(g_rows) * eff_dim(g_cols_a);
    case (eff_op(g_mode))
      OP_ADD:      return 2 * a_len;
      OP_MULTIPLY: return a_len + eff_dim(g_cols_a) * eff_dim(g_cols_b);
      default:     return a_len;
    endcase
  endfunction

  task automatic put_elem(input logic [ELEM_W-1:0] e);
    stim_t s;
    s.kind    = ST_ELEM;
    s.element = e;
    s.index   = '0;
    s.data    = '0;
    stim_q.push_back(s);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_t s;
    s.kind    = ST_REG;
    s.element = '0;
    s.index   = idx;
    s.data    = data;
    stim_q.push_back(s);
    case (idx)
      REG_MODE:   g_mode = data[1:0];
      REG_ROWS_A: g_rows = data;
      REG_COLS_A: g_cols_a = data;
      REG_COLS_B: g_cols_b = data;
      default: ;
    endcase
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // handshake sampling, prediction, checking and watchdog
  always @(posedge clk) begin
    elem_fire = elem_ch.valid === 1'b1 && elem_ch.ready === 1'b1;
    reg_fire  = reg_ch.valid === 1'b1 && reg_ch.ready === 1'b1;
    word_out  = res_ch.valid === 1'b1 && res_ch.ready === 1'b1;
    if (rst) begin
      quiet = 0;
    end else begin
      if (reg_fire) apply_register(reg_ch.index, reg_ch.data);
      if (elem_fire) absorb_element(elem_ch.element);
      if (word_out) check_result();
      if (elem_fire || reg_fire || word_out) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL small_matrix_add_multiply_transpose_core");
        $finish;
      end
    end
  end

  // driver: element and register words from the pending queue, result ready stalls
  always @(negedge clk) begin
    if (!rst) begin
      // alternate calm stretches with stretches of random idling
      if (src_calm_left > 0) begin
        src_calm_left--;
      end else begin
        src_calm      = !src_calm;
        src_calm_left = src_calm ? $urandom_range(30, 120) : $urandom_range(60, 300);
      end
      if (snk_calm_left > 0) begin
        snk_calm_left--;
      end else begin
        snk_calm      = !snk_calm;
        snk_calm_left = snk_calm ? $urandom_range(30, 120) : $urandom_range(60, 300);
      end

      up_valid = elem_ch.valid && !elem_fire;
      up_reg   = reg_ch.valid && !reg_fire;
      if (elem_fire || reg_fire) holding = 1'b0;
      if (!holding && stim_q.size() != 0) begin
        cur       = stim_q.pop_front();
        holding   = 1'b1;
        gap_left  = src_calm ? 0 : idle_len();
        hold_left = HOLD_OFF;
      end
      if (holding && !up_valid && !up_reg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cur.kind == ST_ELEM) begin
          up_valid = 1'b1;
          elem_ch.element <= cur.element;
        end else if (due_results.size() != 0) begin
          // register writes wait until the engine has drained
          hold_left = HOLD_OFF;
        end else if (hold_left > 0) begin
          hold_left--;
        end else begin
          up_reg = 1'b1;
          reg_ch.index <= cur.index;
          reg_ch.data  <= cur.data;
        end
      end
      elem_ch.valid <= up_valid;
      reg_ch.valid  <= up_reg;

      // result side back-pressure
      if (stall_left > 0) stall_left--;
      else if (!snk_calm) stall_left = idle_len();
      res_ch.ready <= (stall_left == 0);
    end
  end

  // stimulus and end of run
  initial begin
    int n_words, len, a_len, cut, style, i;
    logic [DIM_W-1:0] d;
    rst             = 1'b1;
    elem_ch.valid   = 1'b0;
    elem_ch.element = '0;
    reg_ch.valid    = 1'b0;
    reg_ch.index    = '0;
    reg_ch.data     = '0;
    res_ch.ready    = 1'b0;
    holding         = 1'b0;
    gap_left        = 0;
    hold_left       = 0;
    stall_left      = 0;
    src_calm        = 1'b0;
    snk_calm        = 1'b1;
    src_calm_left   = 0;
    snk_calm_left   = 0;
    elem_fire       = 1'b0;
    reg_fire        = 1'b0;
    word_out        = 1'b0;
    quiet           = 0;
    bad_count       = 0;
    m_mode          = OP_ADD;
    m_rows          = DIM_W'(MAX_DIM);
    m_cols_a        = DIM_W'(MAX_DIM);
    m_cols_b        = DIM_W'(MAX_DIM);
    m_loaded        = 0;
    g_mode          = OP_ADD;
    g_rows          = DIM_W'(MAX_DIM);
    g_cols_a        = DIM_W'(MAX_DIM);
    g_cols_b        = DIM_W'(MAX_DIM);
    n_words         = 0;

    // add 1x1 at both extremes
    put_reg(REG_ROWS_A, 4'd1);
    put_reg(REG_COLS_A, 4'd1);
    put_elem(16'h7fff); put_elem(16'h7fff);
    put_elem(16'h8000); put_elem(16'h8000);
    n_words += 4;
    // multiply with zero dimensions acting as one
    put_reg(REG_MODE, CFG_DATA_W'(OP_MULTIPLY));
    put_reg(REG_ROWS_A, 4'd0);
    put_reg(REG_COLS_A, 4'd2);
    put_reg(REG_COLS_B, 4'd0);
    repeat (4) put_elem(16'h8000);
    n_words += 4;
    // transpose 2x3
    put_reg(REG_MODE, CFG_DATA_W'(OP_TRANSPOSE));
    put_reg(REG_ROWS_A, 4'd2);
    put_reg(REG_COLS_A, 4'd3);
    put_elem(16'h0000); put_elem(16'hffff); put_elem(16'h0001);
    put_elem(16'h5555); put_elem(16'haaaa); put_elem(16'h7ffe);
    n_words += 6;
    // spare mode acts as add; a write past the list must not restart the load
    put_reg(REG_MODE, MODE_SPARE);
    put_reg(REG_ROWS_A, 4'd1);
    put_reg(REG_COLS_A, 4'd2);
    put_elem(16'd100); put_elem(-16'sd200);
    put_reg(JUNK_INDEX, 4'd0);
    put_elem(16'd300); put_elem(-16'sd400);
    n_words += 4;
    // oversized row count acts as the maximum
    put_reg(REG_MODE, CFG_DATA_W'(OP_TRANSPOSE));
    put_reg(REG_ROWS_A, 4'd15);
    put_reg(REG_COLS_A, 4'd1);
    for (i = 0; i < MAX_DIM; i++) put_elem(rand_element());
    n_words += MAX_DIM;

    // largest product, then most negative dot product
    put_reg(REG_MODE, CFG_DATA_W'(OP_MULTIPLY));
    put_reg(REG_ROWS_A, DIM_W'(MAX_DIM));
    put_reg(REG_COLS_A, DIM_W'(MAX_DIM));
    put_reg(REG_COLS_B, DIM_W'(MAX_DIM));
    len = load_len();
    for (i = 0; i < len; i++) put_elem(16'h8000);
    n_words += len;
    put_reg(REG_ROWS_A, 4'd1);
    put_reg(REG_COLS_B, 4'd1);
    for (i = 0; i < MAX_DIM; i++) put_elem(16'h8000);
    for (i = 0; i < MAX_DIM; i++) put_elem(16'h7fff);
    n_words += 2 * MAX_DIM;

    // random passes, now and then a new setting or a broken load
    while (n_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 1) == 0) put_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 99) < 60) put_reg(REG_ROWS_A, pick_dim());
        if ($urandom_range(0, 99) < 60) put_reg(REG_COLS_A, pick_dim());
        if ($urandom_range(0, 99) < 60) put_reg(REG_COLS_B, pick_dim());
        if ($urandom_range(0, 99) < 10)
          put_reg(CFG_IDX_W'($urandom_range(REG_COLS_B + 1, 15)),
                  CFG_DATA_W'($urandom_range(0, 15)));
      end
      len   = load_len();
      a_len = eff_dim(g_rows) * eff_dim(g_cols_a);
      style = $urandom_range(0, 99);
      if (style < 8 && len > 1) begin
        // abandon a load part way, then restart it with a register write
        cut = $urandom_range(1, len - 1);
        for (i = 0; i < cut; i++) put_elem(rand_element());
        n_words += cut;
        d = pick_dim();
        case ($urandom_range(0, 2))
          0:       put_reg(REG_ROWS_A, d);
          1:       put_reg(REG_COLS_A, d);
          default: put_reg(REG_COLS_B, d);
        endcase
      end else if (style < 16) begin
        for (i = 0; i < len; i++)
          put_elem(i < a_len ? 16'h8000 : ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff));
        n_words += len;
      end else begin
        for (i = 0; i < len; i++) put_elem(rand_element());
        n_words += len;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || holding) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (bad_count == 0 && due_results.size() == 0) begin
      $display("PASS small_matrix_add_multiply_transpose_core");
    end else begin
      $display("FAIL small_matrix_add_multiply_transpose_core");
    end
    $finish;
  end

endmodule
